// ----- hdl/efws_pkg.sv -----
// Shared constants and types for the earliest free worker scheduler.
package efws_pkg;

  localparam int TIME_W = 63;
  localparam int DUR_W = 32;
  localparam int CNT_W = 5;
  localparam int OUT_IDX_W = 4;
  localparam int DEF_MAX_WORKERS = 16;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1);

  typedef struct packed {
    logic clear;
    logic advance;
  } cell_ctrl_t;

endpackage

// ----- hdl/efws_cell.sv -----
// One slot of the sorted worker queue, ordered by free time and then index.
module efws_cell #(
  parameter int IDX_W = 4,
  parameter int INDEX = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  efws_pkg::cell_ctrl_t         ctrl,
  input  logic                         active,
  input  logic [efws_pkg::TIME_W-1:0]  ins_time,
  input  logic [IDX_W-1:0]             ins_idx,
  input  logic                         next_lt,
  input  logic [efws_pkg::TIME_W-1:0]  next_time,
  input  logic [IDX_W-1:0]             next_idx,
  output logic [efws_pkg::TIME_W-1:0]  key_time,
  output logic [IDX_W-1:0]             key_idx,
  output logic                         lt
);
  import efws_pkg::*;

  localparam bit FIRST = (INDEX == 0);

  assign lt = active && ((key_time < ins_time) ||
                         ((key_time == ins_time) && (key_idx < ins_idx)));

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      key_time <= '0;
      key_idx  <= IDX_W'(INDEX);
    end else if (ctrl.advance && active) begin
      if (next_lt) begin
        key_time <= next_time;
        key_idx  <= next_idx;
      end else if (lt || FIRST) begin
        key_time <= ins_time;
        key_idx  <= ins_idx;
      end
    end
  end

endmodule

// ----- hdl/earliest_free_worker_scheduler_unit.sv -----
// Top level of the earliest free worker scheduler built on a sorted cell row.
// The result register loads at the edge that accepts the item.
// Throughput: one item per cycle while results are taken; a result held by out_stall
// stalls the input. The saturating add on the head slot and the key compare in every
// cell of the row are both combinational and complete before the accepting edge.
// Reset: synchronous; free times clear to zero, worker count becomes one.
// A configuration write clears the free times in the same cycle.
module earliest_free_worker_scheduler_unit #(
  parameter int MAX_WORKERS = efws_pkg::DEF_MAX_WORKERS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [efws_pkg::CNT_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [efws_pkg::DUR_W-1:0]      job_duration,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [efws_pkg::OUT_IDX_W-1:0]  worker_index,
  output logic [efws_pkg::TIME_W-1:0]     start_time,
  output logic                            saturated
);
  import efws_pkg::*;

  localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;

  logic [CNT_W-1:0]   worker_count;
  logic               in_acc;
  logic               cfg_acc;
  cell_ctrl_t         ctrl;
  logic [TIME_W:0]    sum;
  logic               sat_next;
  logic [TIME_W-1:0]  ins_time;
  logic [IDX_W-1:0]   ins_idx;

  logic [TIME_W-1:0]  cell_time [MAX_WORKERS+1];
  logic [IDX_W-1:0]   cell_idx  [MAX_WORKERS+1];
  logic               cell_lt   [MAX_WORKERS+1];
  logic [MAX_WORKERS-1:0] active;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_stall  = out_valid && out_stall;
  assign in_acc    = in_valid && !in_stall;

  assign ctrl.clear   = cfg_acc;
  assign ctrl.advance = in_acc;

  assign sum      = {1'b0, cell_time[0]} + (TIME_W+1)'(job_duration);
  assign sat_next = sum[TIME_W];
  assign ins_time = sat_next ? TIME_MAX : sum[TIME_W-1:0];
  assign ins_idx  = cell_idx[0];

  assign cell_time[MAX_WORKERS] = '0;
  assign cell_idx[MAX_WORKERS]  = '0;
  assign cell_lt[MAX_WORKERS]   = 1'b0;

  for (genvar i = 0; i < MAX_WORKERS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign active[i] = 1'b1;
    end else begin : g_tail
      assign active[i] = (32'(worker_count) > i);
    end

    efws_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .active    (active[i]),
      .ins_time  (ins_time),
      .ins_idx   (ins_idx),
      .next_lt   (cell_lt[i+1]),
      .next_time (cell_time[i+1]),
      .next_idx  (cell_idx[i+1]),
      .key_time  (cell_time[i]),
      .key_idx   (cell_idx[i]),
      .lt        (cell_lt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      worker_count <= COUNT_RESET;
    end else if (cfg_acc) begin
      worker_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      worker_index <= OUT_IDX_W'(cell_idx[0]);
      start_time   <= cell_time[0];
      saturated    <= sat_next;
    end
  end

endmodule

// ----- hdl/efws_checker.sv -----
// Port-level checks for the scheduler and the bind that attaches them.
module efws_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [efws_pkg::OUT_IDX_W-1:0]  worker_index,
  input logic [efws_pkg::TIME_W-1:0]     start_time,
  input logic                            saturated
);
  import efws_pkg::*;

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("Output valid right after reset.");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("Input stalled while the output register could take an item.");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("Accepted item produced no result.");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(worker_index) &&
                                  $stable(start_time) && $stable(saturated)))
    else $error("Stalled result changed.");

endmodule

bind earliest_free_worker_scheduler_unit efws_checker u_efws_checker (.*);
